@@ hw/rtl/blzd_pkg.sv @@
package blzd_pkg;

    localparam int WindowDepth  = 65536;
    localparam int TableEntries = 52;

    localparam logic [2:0] ST_BYTE   = 3'd0;
    localparam logic [2:0] ST_NEED   = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_ACCEPT = 3'd3;
    localparam logic [2:0] ST_REJECT = 3'd4;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_byte;
        logic [15:0] out_addr;
    } rsp_t;

endpackage

@@ hw/rtl/blzd_ram.sv @@
module blzd_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/blzd_front.sv @@
module blzd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  blzd_pkg::req_t    s_req,
    output logic              q_valid,
    input  logic              q_ready,
    output blzd_pkg::req_t    q_req
);
    import blzd_pkg::*;

    // two-entry request queue
    req_t   buf_reg [2];
    logic   [1:0] cnt_reg;
    logic   rd_reg, wr_reg;
    logic   push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= s_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ hw/rtl/blzd_back.sv @@
module blzd_back #(
    parameter int WindowDepth = blzd_pkg::WindowDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  blzd_pkg::req_t   q_req,
    output logic             m_tvalid,
    input  logic             m_tready,
    output blzd_pkg::rsp_t   m_rsp
);
    import blzd_pkg::*;

    localparam int AW = $clog2(WindowDepth);
    localparam int TE = TableEntries;

    localparam logic [3:0] PH_HDR_HI = 4'd0;
    localparam logic [3:0] PH_HDR_LO = 4'd1;
    localparam logic [3:0] PH_SEED   = 4'd2;
    localparam logic [3:0] PH_TABLE  = 4'd3;
    localparam logic [3:0] PH_TOKEN  = 4'd4;
    localparam logic [3:0] PH_GAMMA  = 4'd5;
    localparam logic [3:0] PH_RAWLEN = 4'd6;
    localparam logic [3:0] PH_RAW    = 4'd7;
    localparam logic [3:0] PH_LEN    = 4'd8;
    localparam logic [3:0] PH_OFFSEL = 4'd9;
    localparam logic [3:0] PH_OFF    = 4'd10;
    localparam logic [3:0] PH_COPY   = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;
    localparam logic [3:0] PH_OFFW   = 4'd13;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [1:0]  st_reg, st_next;
    logic [3:0]  ph_reg, ph_next;
    logic [7:0]  hb_reg, hb_next;
    logic        hv_reg, hv_next;
    logic [8:0]  bs_reg, bs_next;
    logic [15:0] wp_reg, wp_next;
    logic [15:0] rl_reg, rl_next;
    logic [15:0] cs_reg, cs_next;
    logic [15:0] ba_reg, ba_next;
    logic [4:0]  bl_reg, bl_next;
    logic [5:0]  tc_reg, tc_next;
    logic [15:0] nb_reg, nb_next;
    logic        tw;
    logic [5:0]  twi;
    logic [15:0] twb;
    logic [3:0]  tww;
    logic [5:0]  tra;
    logic [19:0] tab_rd;
    logic [15:0] tb_base;
    logic [3:0]  tb_wid;
    logic        ov_reg, ov_next;
    rsp_t        rsp_reg, rsp_next;

    logic        we;
    logic [7:0]  wdata;
    logic [7:0]  rdata;

    function automatic logic [5:0] clampi(input logic [6:0] v);
        clampi = (v < 7'(TE)) ? v[5:0] : 6'(TE - 1);
    endfunction

    assign q_ready  = (st_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_rsp    = rsp_reg;

    // table read data always follows the current table index
    assign tra     = clampi({1'b0, tc_next});
    assign tb_base = tab_rd[19:4];
    assign tb_wid  = tab_rd[3:0];

    blzd_ram #(.Width(8), .Depth(WindowDepth)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (wp_next[AW-1:0]),
        .wdata (wdata),
        .raddr (cs_next[AW-1:0]),
        .rdata (rdata)
    );

    blzd_ram #(.Width(20), .Depth(TE)) u_tab (
        .clk   (clk),
        .we    (tw),
        .waddr (twi),
        .wdata ({twb, tww}),
        .raddr (tra),
        .rdata (tab_rd)
    );

    always_comb
    begin
        logic [5:0]  ci;
        logic [16:0] len;
        logic [1:0]  cls;
        logic        emit;
        logic [7:0]  eb;
        logic [15:0] v;
        st_next = st_reg; ph_next = ph_reg; hb_next = hb_reg; hv_next = hv_reg;
        bs_next = bs_reg; wp_next = wp_reg; rl_next = rl_reg; cs_next = cs_reg;
        ba_next = ba_reg; bl_next = bl_reg; tc_next = tc_reg; nb_next = nb_reg;
        ov_next = ov_reg; rsp_next = rsp_reg;
        if (m_tvalid && m_tready)
        begin
            ov_next = 1'b0;
        end
        tw = 1'b0; twi = '0; twb = '0; tww = '0;
        we = 1'b0; wdata = '0;
        emit = 1'b0; eb = '0;
        ci = clampi({1'b0, tc_reg});
        len = '0; cls = '0; v = '0;
        case (st_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    if (q_req.req_type == REQ_OFFER)
                    begin
                        ov_next = 1'b1;
                        rsp_next = '0;
                        if (hv_reg || ph_reg == PH_DONE)
                        begin
                            rsp_next.status = ST_REJECT;
                        end
                        else
                        begin
                            hb_next = q_req.in_byte;
                            hv_next = 1'b1;
                            rsp_next.status = ST_ACCEPT;
                        end
                    end
                    else
                    begin
                        st_next = S_RUN;
                    end
                end
            end
            S_RD:
            begin
                emit = 1'b1;
                eb = rdata;
            end
            default:
            begin
                // one bit or one phase transition per cycle
                if (bl_reg != 5'd0 && ph_reg != PH_RAW && ph_reg != PH_COPY)
                begin
                    if (bs_reg == 9'd1 && !hv_reg)
                    begin
                        ov_next = 1'b1; st_next = S_IDLE;
                        rsp_next = '0; rsp_next.status = ST_NEED;
                    end
                    else
                    begin
                        logic [8:0] b;
                        b = (bs_reg == 9'd1) ? {1'b1, hb_reg} : bs_reg;
                        if (bs_reg == 9'd1)
                        begin
                            hv_next = 1'b0;
                        end
                        ba_next = {ba_reg[14:0], b[0]};
                        bs_next = b >> 1;
                        bl_next = bl_reg - 5'd1;
                    end
                end
                else
                begin
                    case (ph_reg)
                        PH_HDR_HI, PH_HDR_LO, PH_SEED, PH_RAW:
                        begin
                            if (!hv_reg)
                            begin
                                ov_next = 1'b1; st_next = S_IDLE;
                                rsp_next = '0; rsp_next.status = ST_NEED;
                            end
                            else
                            begin
                                hv_next = 1'b0;
                                if (ph_reg == PH_HDR_HI)
                                begin
                                    wp_next = {hb_reg, 8'd0}; ph_next = PH_HDR_LO;
                                end
                                else if (ph_reg == PH_HDR_LO)
                                begin
                                    wp_next = {wp_reg[15:8], hb_reg}; ph_next = PH_SEED;
                                end
                                else if (ph_reg == PH_SEED)
                                begin
                                    bs_next = {1'b0, hb_reg}; tc_next = '0;
                                    ph_next = PH_TABLE; bl_next = 5'd4; ba_next = '0;
                                end
                                else
                                begin
                                    emit = 1'b1; eb = hb_reg;
                                end
                            end
                        end
                        PH_TABLE:
                        begin
                            // entries are built in order, nb_reg carries the next base
                            tw = 1'b1; twi = ci; tww = ba_reg[3:0];
                            twb = (ci[3:0] == 4'd0) ? 16'd1 : nb_reg;
                            nb_next = twb + (16'd1 << ba_reg[3:0]);
                            tc_next = ci + 6'd1;
                            ba_next = '0;
                            if (ci + 6'd1 >= 6'(TE))
                            begin
                                ph_next = PH_TOKEN; bl_next = 5'd1;
                            end
                            else
                            begin
                                bl_next = 5'd4;
                            end
                        end
                        PH_TOKEN:
                        begin
                            if (ba_reg[0])
                            begin
                                rl_next = 16'd1; ph_next = PH_RAW;
                            end
                            else
                            begin
                                tc_next = '0; ph_next = PH_GAMMA;
                                bl_next = 5'd1; ba_next = '0;
                            end
                        end
                        PH_GAMMA:
                        begin
                            ba_next = '0;
                            if (!ba_reg[0])
                            begin
                                tc_next = tc_reg + 6'd1;
                                if (tc_reg + 6'd1 >= 6'd17)
                                begin
                                    ph_next = PH_DONE;
                                end
                                else
                                begin
                                    bl_next = 5'd1;
                                end
                            end
                            else if (tc_reg == 6'd16)
                            begin
                                ph_next = PH_RAWLEN; bl_next = 5'd16;
                            end
                            else
                            begin
                                ph_next = PH_LEN; bl_next = {1'b0, tb_wid};
                            end
                        end
                        PH_RAWLEN:
                        begin
                            rl_next = ba_reg; ph_next = PH_RAW;
                        end
                        PH_LEN:
                        begin
                            len = {1'b0, tb_base} + {1'b0, ba_reg};
                            rl_next = len[16] ? 16'hFFFF : len[15:0];
                            cls = (len <= 17'd1) ? 2'd0 : ((len == 17'd2) ? 2'd1 : 2'd2);
                            tc_next = (cls == 2'd0) ? 6'd48 : ((cls == 2'd1) ? 6'd32 : 6'd16);
                            bl_next = (cls == 2'd0) ? 5'd2 : 5'd4;
                            ph_next = PH_OFFSEL; ba_next = '0;
                        end
                        PH_OFFSEL:
                        begin
                            tc_next = clampi({1'b0, tc_reg} + ba_reg[6:0]);
                            bl_next = 5'd0;
                            ph_next = PH_OFFW; ba_next = '0;
                        end
                        PH_OFFW:
                        begin
                            // width of the selected offset class is read here
                            bl_next = {1'b0, tb_wid};
                            ph_next = PH_OFF;
                        end
                        PH_OFF:
                        begin
                            v = tb_base + ba_reg;
                            cs_next = wp_reg + v; ph_next = PH_COPY;
                        end
                        PH_COPY:
                        begin
                            cs_next = cs_reg - 16'd1; st_next = S_RD;
                        end
                        default:
                        begin
                            ph_next = PH_DONE;
                            ov_next = 1'b1; st_next = S_IDLE;
                            rsp_next = '0; rsp_next.status = ST_DONE;
                            rsp_next.out_addr = wp_reg;
                        end
                    endcase
                end
            end
        endcase
        if (emit)
        begin
            wp_next = wp_reg - 16'd1;
            we = 1'b1; wdata = eb;
            if (rl_reg <= 16'd1)
            begin
                ph_next = PH_TOKEN; bl_next = 5'd1; ba_next = '0;
            end
            else
            begin
                rl_next = rl_reg - 16'd1;
            end
            ov_next = 1'b1; st_next = S_IDLE;
            rsp_next.status = ST_BYTE; rsp_next.out_byte = eb;
            rsp_next.out_addr = wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ph_reg <= PH_HDR_HI; hb_reg <= '0; hv_reg <= 1'b0;
            bs_reg <= '0; wp_reg <= '0; rl_reg <= '0; cs_reg <= '0;
            ba_reg <= '0; bl_reg <= '0; tc_reg <= '0; ov_reg <= 1'b0;
            nb_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; ph_reg <= ph_next; hb_reg <= hb_next; hv_reg <= hv_next;
            bs_reg <= bs_next; wp_reg <= wp_next; rl_reg <= rl_next; cs_reg <= cs_next;
            ba_reg <= ba_next; bl_reg <= bl_next; tc_reg <= tc_next; ov_reg <= ov_next;
            nb_reg <= nb_next;
        end
    end
endmodule

@@ hw/rtl/backward_lz_bitstream_decompressor.sv @@
// Timing: an offer is answered straight from the idle state; a step request runs the
// decode sequencer over each stream bit or decode phase it consumes, and a copied byte is first read from the history.
// Throughput: one request at a time in the decoder sequencer; the two-entry request
// queue keeps accepting while a response waits, until it is full.
// Reset: rst_n asynchronous, active low; history and tables undefined.
module backward_lz_bitstream_decompressor #(
    parameter int WindowDepth = blzd_pkg::WindowDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_byte, out_addr
    output logic [2:0]  m_tuser    // status
);
    import blzd_pkg::*;

    req_t s_req, q_req;
    rsp_t rsp;
    logic q_valid, q_ready;

    assign s_req.req_type = s_tuser;
    assign s_req.in_byte  = s_tdata;
    assign m_tdata = {rsp.out_addr, rsp.out_byte};
    assign m_tuser = rsp.status;

    blzd_front u_front (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_req(s_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    blzd_back #(.WindowDepth(WindowDepth)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_req(q_req), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_rsp(rsp)
    );
endmodule

@@ dv/blzd_checker.sv @@
module blzd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          errors,
    output int          pending,
    output logic        hold_full,
    output logic        stream_done
);
    timeunit 1ns;
    timeprecision 1ps;
    import blzd_pkg::*;

    typedef enum logic [3:0] {
        PH_HDR_HI, PH_HDR_LO, PH_SEED, PH_TABLE, PH_TOKEN, PH_GAMMA, PH_RAWLEN,
        PH_RAW, PH_LEN, PH_OFFSEL, PH_OFF, PH_COPY, PH_DONE
    } phase_e;

    localparam int GammaRaw = 16;
    localparam int GammaEnd = 17;

    logic [7:0]  history [WindowDepth];
    logic [15:0] base_tbl [TableEntries];
    logic [3:0]  width_tbl [TableEntries];
    logic [7:0]  hold_byte;
    logic        hold_valid;
    logic [8:0]  bit_shift;
    logic [15:0] write_pos;
    phase_e      phase;
    logic [15:0] run_length;
    logic [15:0] copy_src;
    logic [15:0] bit_accum;
    logic [4:0]  bits_left;
    logic [5:0]  tcount;

    rsp_t expected_rsp [$];

    function automatic int unsigned clamp_idx(int unsigned v);
        return (v < TableEntries) ? v : TableEntries - 1;
    endfunction

    function automatic void begin_read(phase_e nxt, int unsigned n);
        phase = nxt;
        bits_left = 5'(n);
        bit_accum = '0;
    endfunction

    function automatic logic pull_bits();
        while (bits_left > 0)
        begin
            if (bit_shift == 9'd1)
            begin
                if (!hold_valid)
                    return 1'b0;
                bit_shift = {1'b1, hold_byte};
                hold_valid = 1'b0;
            end
            bit_accum = {bit_accum[14:0], bit_shift[0]};
            bit_shift = bit_shift >> 1;
            bits_left--;
        end
        return 1'b1;
    endfunction

    function automatic rsp_t emit(logic [7:0] b);
        rsp_t r;
        write_pos = write_pos - 16'd1;
        history[write_pos] = b;
        if (run_length <= 1)
            begin_read(PH_TOKEN, 1);
        else
            run_length--;
        r.status = ST_BYTE;
        r.out_byte = b;
        r.out_addr = write_pos;
        return r;
    endfunction

    function automatic rsp_t decode_request(logic rt, logic [7:0] b);
        rsp_t r;
        logic go;
        int unsigned i;
        int unsigned v;
        int unsigned len;
        int unsigned cls;
        r = '{status: ST_NEED, out_byte: 8'd0, out_addr: 16'd0};
        go = 1'b1;
        if (rt == REQ_OFFER)
        begin
            if (hold_valid || phase == PH_DONE)
                r.status = ST_REJECT;
            else
            begin
                hold_byte = b;
                hold_valid = 1'b1;
                r.status = ST_ACCEPT;
            end
            return r;
        end
        while (go)
        begin
            case (phase)
                PH_HDR_HI, PH_HDR_LO, PH_SEED:
                begin
                    if (!hold_valid)
                        go = 1'b0;
                    else
                    begin
                        hold_valid = 1'b0;
                        if (phase == PH_HDR_HI)
                        begin
                            write_pos = {hold_byte, 8'd0};
                            phase = PH_HDR_LO;
                        end
                        else if (phase == PH_HDR_LO)
                        begin
                            write_pos[7:0] = hold_byte;
                            phase = PH_SEED;
                        end
                        else
                        begin
                            bit_shift = {1'b0, hold_byte};
                            tcount = '0;
                            begin_read(PH_TABLE, 4);
                        end
                    end
                end
                PH_TABLE:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else
                    begin
                        i = clamp_idx(tcount);
                        if (i[3:0] == 4'd0)
                            base_tbl[i] = 16'd1;
                        else
                            base_tbl[i] = 16'(base_tbl[i-1] + (32'd1 << width_tbl[i-1]));
                        width_tbl[i] = bit_accum[3:0];
                        tcount = 6'(i + 1);
                        if (tcount >= TableEntries)
                            begin_read(PH_TOKEN, 1);
                        else
                            begin_read(PH_TABLE, 4);
                    end
                end
                PH_TOKEN:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else if (bit_accum[0])
                    begin
                        run_length = 16'd1;
                        phase = PH_RAW;
                    end
                    else
                    begin
                        tcount = '0;
                        begin_read(PH_GAMMA, 1);
                    end
                end
                PH_GAMMA:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else if (!bit_accum[0])
                    begin
                        tcount++;
                        if (tcount >= GammaEnd)
                            phase = PH_DONE;
                        else
                            begin_read(PH_GAMMA, 1);
                    end
                    else if (tcount == GammaRaw)
                        begin_read(PH_RAWLEN, 16);
                    else
                        begin_read(PH_LEN, width_tbl[clamp_idx(tcount)]);
                end
                PH_RAWLEN:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else
                    begin
                        run_length = bit_accum;
                        phase = PH_RAW;
                    end
                end
                PH_RAW:
                begin
                    go = 1'b0;
                    if (hold_valid)
                    begin
                        hold_valid = 1'b0;
                        r = emit(hold_byte);
                    end
                end
                PH_LEN:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else
                    begin
                        len = base_tbl[clamp_idx(tcount)] + bit_accum;
                        run_length = (len > 32'hFFFF) ? 16'hFFFF : 16'(len);
                        cls = (len <= 1) ? 0 : ((len == 2) ? 1 : 2);
                        tcount = (cls == 0) ? 6'd48 : ((cls == 1) ? 6'd32 : 6'd16);
                        begin_read(PH_OFFSEL, (cls == 0) ? 2 : 4);
                    end
                end
                PH_OFFSEL:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else
                    begin
                        v = clamp_idx(tcount + bit_accum);
                        tcount = 6'(v);
                        begin_read(PH_OFF, width_tbl[v]);
                    end
                end
                PH_OFF:
                begin
                    if (!pull_bits())
                        go = 1'b0;
                    else
                    begin
                        v = base_tbl[clamp_idx(tcount)] + bit_accum;
                        copy_src = 16'(write_pos + v);
                        phase = PH_COPY;
                    end
                end
                PH_COPY:
                begin
                    copy_src = copy_src - 16'd1;
                    r = emit(history[copy_src]);
                    go = 1'b0;
                end
                default:
                begin
                    phase = PH_DONE;
                    r.status = ST_DONE;
                    r.out_addr = write_pos;
                    go = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            hold_byte = '0;
            hold_valid = 1'b0;
            bit_shift = '0;
            write_pos = '0;
            phase = PH_HDR_HI;
            run_length = '0;
            copy_src = '0;
            bit_accum = '0;
            bits_left = '0;
            tcount = '0;
            expected_rsp.delete();
            errors = 0;
            pending <= 0;
            hold_full <= 1'b0;
            stream_done <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected response: status %0d byte %02h addr %04h",
                                 m_tuser, m_tdata[7:0], m_tdata[23:8]);
                end
                else
                begin
                    exp_r = expected_rsp.pop_front();
                    if (m_tuser !== exp_r.status || m_tdata[7:0] !== exp_r.out_byte ||
                        m_tdata[23:8] !== exp_r.out_addr)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp status %0d byte %02h addr %04h, got %0d %02h %04h",
                                     exp_r.status, exp_r.out_byte, exp_r.out_addr,
                                     m_tuser, m_tdata[7:0], m_tdata[23:8]);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_rsp.push_back(decode_request(s_tuser, s_tdata));
            pending <= expected_rsp.size();
            hold_full <= hold_valid;
            stream_done <= (phase == PH_DONE);
        end
    end

endmodule

@@ dv/backward_lz_bitstream_decompressor_test.sv @@
module backward_lz_bitstream_decompressor_test;
    timeunit 1ns;
    timeprecision 1ps;
    import blzd_pkg::*;

    localparam int CycleLimit = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // in_byte
    logic        s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // out_byte, out_addr
    logic [2:0]  m_tuser;   // status

    int   errors;
    int   pending;
    logic hold_full;
    logic stream_done;
    logic calm;
    logic long_hold;
    int   cycles;

    logic [7:0]  comp_bytes [$];
    int          bit_idx;
    int          bit_pos;
    int          bit_lim;
    int          out_count;
    logic [15:0] enc_base [TableEntries];
    logic [3:0]  enc_width [TableEntries];

    backward_lz_bitstream_decompressor uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    blzd_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .hold_full(hold_full),
        .stream_done(stream_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("backward_lz_bitstream_decompressor_test NOT OK");
            $finish;
        end
    end

    task automatic put_bit(logic b);
        if (bit_pos == bit_lim)
        begin
            comp_bytes.push_back(8'd0);
            bit_idx = comp_bytes.size() - 1;
            bit_pos = 0;
            bit_lim = 8;
        end
        comp_bytes[bit_idx][bit_pos] = b;
        bit_pos++;
    endtask

    task automatic put_field(logic [15:0] val, int n);
        for (int k = n - 1; k >= 0; k--)
            put_bit(val[k]);
    endtask

    task automatic put_gamma(int g);
        put_bit(1'b0);
        repeat (g) put_bit(1'b0);
        put_bit(1'b1);
    endtask

    task automatic put_literal(logic [7:0] b);
        put_bit(1'b1);
        comp_bytes.push_back(b);
        out_count++;
    endtask

    task automatic put_run(int len);
        put_gamma(16);
        put_field(16'(len), 16);
        repeat ((len < 1) ? 1 : len) comp_bytes.push_back(8'($urandom));
        out_count += (len < 1) ? 1 : len;
    endtask

    task automatic put_match();
        int g, e, len, nsel, sel, oi, e2, v;
        logic ok;
        ok = 1'b0;
        for (int t = 0; t < 20 && !ok; t++)
        begin
            g = $urandom_range(0, 15);
            e = $urandom & ((1 << enc_width[g]) - 1);
            len = enc_base[g] + e;
            nsel = (len <= 1) ? 2 : 4;
            sel = $urandom & ((1 << nsel) - 1);
            oi = ((len <= 1) ? 48 : ((len == 2) ? 32 : 16)) + sel;
            e2 = $urandom & ((1 << enc_width[oi]) - 1);
            v = (enc_base[oi] + e2) & 16'hFFFF;
            ok = (len <= 40) && (v >= 1) && (v <= out_count);
        end
        if (!ok)
            put_literal(8'($urandom));
        else
        begin
            put_gamma(g);
            put_field(16'(e), enc_width[g]);
            put_field(16'(sel), nsel);
            put_field(16'(e2), enc_width[oi]);
            out_count += (len < 1) ? 1 : len;
        end
    endtask

    task automatic build_stream();
        int k;
        int r;
        logic [15:0] end_addr;
        end_addr = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom);
        comp_bytes.push_back(end_addr[15:8]);
        comp_bytes.push_back(end_addr[7:0]);
        k = $urandom_range(0, 7);
        comp_bytes.push_back(8'(1 << k));
        bit_idx = 2;
        bit_pos = 0;
        bit_lim = k;
        for (int i = 0; i < TableEntries; i++)
        begin
            enc_width[i] = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
            if (i % 16 == 0)
                enc_base[i] = 16'd1;
            else
                enc_base[i] = 16'(enc_base[i-1] + (32'd1 << enc_width[i-1]));
            put_field(16'(enc_width[i]), 4);
        end
        out_count = 0;
        put_literal(8'h00);
        put_literal(8'hFF);
        put_run(0);
        put_run(1);
        put_run(3);
        repeat (6) put_match();
        while (out_count + comp_bytes.size() < 1500)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                put_literal(8'($urandom));
            else if (r == 3)
                put_run($urandom_range(0, 6));
            else
                put_match();
        end
        put_bit(1'b0);
        repeat (17) put_bit(1'b0);
    endtask

    task automatic send(logic rt, logic [7:0] b);
        s_tvalid <= 1'b1;
        s_tuser <= rt;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic idle(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        logic long_done;
        long_done = 1'b0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && !long_done)
            begin
                long_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int idx;
        int nreq;
        int gap;
        logic known_full;
        logic after_step;
        logic held_back;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = REQ_OFFER;
        s_tdata = 8'd0;
        calm = 1'b0;
        long_hold = 1'b0;
        bit_pos = 0;
        bit_lim = 0;
        build_stream();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idx = 0;
        nreq = 0;
        known_full = 1'b0;
        after_step = 1'b0;
        held_back = 1'b0;
        while (!(stream_done && !after_step))
        begin
            gap = after_step ? 1 : 0;
            if (!calm && $urandom_range(0, 4) == 0)
                gap = $urandom_range(1, 7);
            if (nreq == 400)
                long_hold <= 1'b1;
            if (nreq == 900 && !held_back)
            begin
                held_back = 1'b1;
                idle(1);
                while (pending != 0)
                    @(posedge clk);
                gap = 0;
            end
            if (gap > 0)
                idle(gap);
            if (after_step)
                known_full = hold_full;
            after_step = 1'b0;
            if (stream_done)
                break;
            if (idx > comp_bytes.size() * 85 / 100)
                calm <= 1'b1;
            if (known_full)
            begin
                if ($urandom_range(0, 9) == 0)
                    send(REQ_OFFER, 8'($urandom));
                else
                begin
                    send(REQ_STEP, 8'($urandom));
                    after_step = 1'b1;
                end
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                send(REQ_STEP, 8'($urandom));
                after_step = 1'b1;
            end
            else
            begin
                send(REQ_OFFER, (idx < comp_bytes.size()) ? comp_bytes[idx] : 8'($urandom));
                idx++;
                known_full = 1'b1;
            end
            nreq++;
        end
        send(REQ_STEP, 8'h00);
        send(REQ_OFFER, 8'hA5);
        send(REQ_STEP, 8'hFF);
        send(REQ_OFFER, 8'h5A);
        idle(1);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("backward_lz_bitstream_decompressor_test OK");
        else
            $display("backward_lz_bitstream_decompressor_test NOT OK");
        $finish;
    end

endmodule

@@ backward_lz_bitstream_decompressor.f @@
hw/rtl/blzd_pkg.sv
hw/rtl/blzd_ram.sv
hw/rtl/blzd_front.sv
hw/rtl/blzd_back.sv
hw/rtl/backward_lz_bitstream_decompressor.sv
dv/blzd_checker.sv
dv/backward_lz_bitstream_decompressor_test.sv
